// ===== hw/rtl/ebcs_pkg.sv =====
// ----------------------------------------------------------------------------
// ebcs_pkg
// shared types, command codes and register indexes of the error blink code
// sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package ebcs_pkg;

  // command codes carried in tuser
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_REPORT  = 2'd1;
  localparam logic [1:0] CMD_RECOVER = 2'd2;
  localparam logic [1:0] CMD_LED     = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_SHORT_TIME    = 3'd0;
  localparam logic [2:0] REG_LONG_TIME     = 3'd1;
  localparam logic [2:0] REG_CODE_ON_TIME  = 3'd2;
  localparam logic [2:0] REG_CODE_GAP_TIME = 3'd3;
  localparam logic [2:0] REG_FIRST_HDR     = 3'd4;
  localparam logic [2:0] REG_LATER_HDR     = 3'd5;
  localparam logic [2:0] REG_BUZZER_EN     = 3'd6;

  localparam int unsigned CmdW     = 2;
  localparam int unsigned CodeW    = 4;
  localparam int unsigned TimeW    = 16;
  localparam int unsigned HdrW     = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned InDataW  = 8;  // error_code + led_level, padded to a byte

  // number of distinct codes; code 0 and codes past the end map to the last one
  localparam int unsigned CODE_COUNT = 10;
  localparam logic [CodeW-1:0] CodeLast = CodeW'(CODE_COUNT - 1);

  typedef logic [TimeW-1:0] time_t;

  typedef struct packed {
    time_t           short_time;
    time_t           long_time;
    time_t           code_on_time;
    time_t           code_gap_time;
    logic [HdrW-1:0] first_hdr;
    logic [HdrW-1:0] later_hdr;
    logic            buzzer_en;
  } cfg_t;

  typedef struct packed {
    logic recovery_led;
    logic all_ok_led;
    logic error_led;
    logic buzzer;
  } flags_t;

  // phase of d ticks reloads the counter with d - 1, a zero length counts as one
  function automatic time_t phase_len(input time_t d);
    return (d == '0) ? '0 : d - time_t'(1);
  endfunction

  // header beep count, zero counts as one
  function automatic logic [HdrW-1:0] hdr_fix(input logic [HdrW-1:0] n);
    return (n == '0) ? HdrW'(1) : n;
  endfunction

  // map code 0 and out of range codes to the last code
  function automatic logic [CodeW-1:0] code_fix(input logic [CodeW-1:0] c);
    return (c == '0 || {1'b0, c} >= (CodeW + 1)'(CODE_COUNT)) ? CodeLast : c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/error_blink_code_sequencer.sv =====
// ----------------------------------------------------------------------------
// error_blink_code_sequencer
// buzzer and led pattern player for a heartbeat and a list of error codes
// ----------------------------------------------------------------------------
// usage
//   slave stream: one command word per transfer, tuser carries the command
//   (tick, report error, recovery, radio led level), tdata the error code and
//   the led level. every accepted word produces exactly one result word on the
//   master stream with the buzzer and led levels and the stored code count,
//   as they stand after the command.
//   configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i;
//   only write while the streams are idle. unknown indexes are ignored.
//   results are registered, in the output register or, under a stall, in the skid register.
//   throughput: one word per cycle while the skid register is empty; the next
//   pattern state is computed combinationally and the code list memory is read
//   ahead at the next code index, so the registered read never holds up a word.
//   stall: a two-entry output stage (output register plus skid register)
//   keeps accepting while one result waits; tready drops only while both
//   entries are full.
//   reset: heartbeat mode, list empty, all-ok led on, registers at defaults.
//   the code list memory is not cleared; only written entries are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module error_blink_code_sequencer #(
  parameter int unsigned MAX_ERRORS = 16,
  localparam int unsigned CntW     = $clog2(MAX_ERRORS + 1),
  localparam int unsigned OutDataW = ((4 + CntW + 7) / 8) * 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // slave stream
  input  wire logic                           s_axis_tvalid,
  output      logic                           s_axis_tready,
  input  wire logic [ebcs_pkg::InDataW-1:0]   s_axis_tdata,  // error_code[3:0], led_level[4]
  input  wire logic [ebcs_pkg::CmdW-1:0]      s_axis_tuser,  // cmd[1:0]
  // master stream
  output      logic                           m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output      logic [OutDataW-1:0]            m_axis_tdata,  // buzzer[0], error_led[1],
                                                             // all_ok_led[2], recovery_led[3],
                                                             // errors_stored[4 +: CntW]
  // configuration write port
  input  wire logic                           cfg_we_i,
  input  wire logic [ebcs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [ebcs_pkg::TimeW-1:0]     cfg_data_i
);
  import ebcs_pkg::*;

  cfg_t                cfg_q;
  flags_t              flags;
  logic [CntW-1:0]     err_total;
  logic                in_acc;
  logic                out_pop;
  logic [OutDataW-1:0] res_word;

  // output register and skid register
  logic                out_vld_q;
  logic [OutDataW-1:0] out_q;
  logic                skid_vld_q;
  logic [OutDataW-1:0] skid_q;

  assign s_axis_tready = !skid_vld_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_pop       = out_vld_q && m_axis_tready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_time    <= TimeW'(100);
      cfg_q.long_time     <= TimeW'(1000);
      cfg_q.code_on_time  <= TimeW'(300);
      cfg_q.code_gap_time <= TimeW'(500);
      cfg_q.first_hdr     <= HdrW'(3);
      cfg_q.later_hdr     <= HdrW'(2);
      cfg_q.buzzer_en     <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SHORT_TIME:    cfg_q.short_time    <= cfg_data_i;
        REG_LONG_TIME:     cfg_q.long_time     <= cfg_data_i;
        REG_CODE_ON_TIME:  cfg_q.code_on_time  <= cfg_data_i;
        REG_CODE_GAP_TIME: cfg_q.code_gap_time <= cfg_data_i;
        REG_FIRST_HDR:     cfg_q.first_hdr     <= cfg_data_i[HdrW-1:0];
        REG_LATER_HDR:     cfg_q.later_hdr     <= cfg_data_i[HdrW-1:0];
        REG_BUZZER_EN:     cfg_q.buzzer_en     <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // pattern state and code list
  ebcs_core #(
    .MAX_ERRORS (MAX_ERRORS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_acc),
    .cmd_i       (s_axis_tuser),
    .code_i      (s_axis_tdata[CodeW-1:0]),
    .level_i     (s_axis_tdata[CodeW]),
    .cfg_i       (cfg_q),
    .flags_o     (flags),
    .err_total_o (err_total)
  );

  // pack result fields from the lowest bit up, zero padded
  assign res_word = OutDataW'({err_total, flags});

  // control of the two-entry output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      // input is held off, skid moves up once the output is taken
      if (out_pop) begin
        skid_vld_q <= 1'b0;
      end
    end else if (in_acc) begin
      if (out_vld_q && !out_pop) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (out_pop) begin
      out_vld_q <= 1'b0;
    end
  end

  // result words
  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_pop) begin
        out_q <= skid_q;
      end
    end else if (in_acc) begin
      if (out_vld_q && !out_pop) begin
        skid_q <= res_word;
      end else begin
        out_q <= res_word;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  // skid entry only ever sits behind a full output register
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register holds a word while output register is empty");

  // a word accepted under a stalled output lands in the skid register
  a_skid_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && out_vld_q && !m_axis_tready) |=> skid_vld_q)
    else $error("accepted word lost under output stall");

  // once a code is stored the all-ok led stays dark
  a_ok_dark : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && err_total != '0) |-> !flags.all_ok_led)
    else $error("all-ok led lit with stored error codes");

  // the error led only lights during a beep
  a_err_led_beep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && flags.error_led && cfg_q.buzzer_en) |-> flags.buzzer)
    else $error("error led lit without a beep");

endmodule

`default_nettype wire

// ===== hw/rtl/ebcs_core.sv =====
// ----------------------------------------------------------------------------
// ebcs_core
// pattern state and stored code list, one command word per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ebcs_core #(
  parameter int unsigned MAX_ERRORS = 16,
  localparam int unsigned CntW = $clog2(MAX_ERRORS + 1),
  localparam int unsigned IdxW = (MAX_ERRORS > 1) ? $clog2(MAX_ERRORS) : 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        step_i,
  input  wire logic [ebcs_pkg::CmdW-1:0]   cmd_i,
  input  wire logic [ebcs_pkg::CodeW-1:0]  code_i,
  input  wire logic                        level_i,
  input  wire ebcs_pkg::cfg_t              cfg_i,
  output      ebcs_pkg::flags_t            flags_o,
  output      logic [CntW-1:0]             err_total_o
);
  import ebcs_pkg::*;

  time_t            ticks_q, ticks_d;
  logic             sig_q, sig_d;
  logic             hb_q, hb_d;
  logic             short_next_q, short_next_d;
  logic [HdrW-1:0]  hdr_q, hdr_d;
  logic [CodeW-1:0] beeps_q, beeps_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  total_q, total_d;
  logic             err_led_q, err_led_d;
  logic             ok_led_q, ok_led_d;
  logic             rec_led_q, rec_led_d;

  // code list memory, registered read of the entry at the next code index
  logic [CodeW-1:0] mem_q [MAX_ERRORS];
  logic [CodeW-1:0] rd_q;
  logic             wr_en;
  logic [IdxW-1:0]  wr_addr;
  logic [CodeW-1:0] wr_data;

  logic [CntW-1:0]  idx_inc;
  logic [CodeW-1:0] beeps_dec;

  assign wr_addr   = total_q[IdxW-1:0];
  assign wr_data   = code_fix(code_i);
  assign idx_inc   = CntW'(idx_q) + CntW'(1);
  assign beeps_dec = (beeps_q != '0) ? beeps_q - CodeW'(1) : '0;

  always_comb begin
    ticks_d      = ticks_q;
    sig_d        = sig_q;
    hb_d         = hb_q;
    short_next_d = short_next_q;
    hdr_d        = hdr_q;
    beeps_d      = beeps_q;
    idx_d        = idx_q;
    total_d      = total_q;
    err_led_d    = err_led_q;
    ok_led_d     = ok_led_q;
    rec_led_d    = rec_led_q;
    wr_en        = 1'b0;
    if (step_i) begin
      case (cmd_i)
        CMD_TICK: begin
          if (ticks_q != '0) begin
            ticks_d = ticks_q - time_t'(1);
          end else if (hb_q) begin
            // heartbeat: short beep, short pause, long beep, long pause
            if (!sig_q) begin
              sig_d   = 1'b1;
              ticks_d = phase_len(short_next_q ? cfg_i.short_time : cfg_i.long_time);
            end else begin
              sig_d = 1'b0;
              if (short_next_q) begin
                short_next_d = 1'b0;
                ticks_d      = phase_len(cfg_i.short_time);
              end else begin
                short_next_d = 1'b1;
                ticks_d      = phase_len(cfg_i.long_time);
                if (total_q != '0) begin
                  hb_d = 1'b0;
                end
              end
            end
          end else if (!sig_q) begin
            sig_d     = 1'b1;
            err_led_d = 1'b1;
            if (beeps_q == '0) begin
              if (hdr_q == '0) begin
                hdr_d = hdr_fix((idx_q == '0) ? cfg_i.first_hdr : cfg_i.later_hdr);
              end
              ticks_d = phase_len(cfg_i.short_time);
            end else begin
              ticks_d = phase_len(cfg_i.code_on_time);
            end
          end else begin
            sig_d     = 1'b0;
            err_led_d = 1'b0;
            if (hdr_q != '0) begin
              hdr_d = hdr_q - HdrW'(1);
              if (hdr_q != HdrW'(1)) begin
                ticks_d = phase_len(cfg_i.short_time);
              end else begin
                beeps_d = rd_q;
                ticks_d = phase_len(cfg_i.code_gap_time);
              end
            end else begin
              beeps_d = beeps_dec;
              if (beeps_dec != '0) begin
                ticks_d = phase_len(cfg_i.code_gap_time);
              end else begin
                ticks_d = phase_len(cfg_i.long_time);
                idx_d   = (idx_inc >= total_q) ? '0 : idx_inc[IdxW-1:0];
              end
            end
          end
        end
        CMD_REPORT: begin
          ok_led_d = 1'b0;
          if (total_q < CntW'(MAX_ERRORS)) begin
            wr_en   = 1'b1;
            total_d = total_q + CntW'(1);
          end
        end
        CMD_RECOVER: begin
          rec_led_d = 1'b1;
        end
        CMD_LED: begin
          if (total_q == '0) begin
            ok_led_d = level_i;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q      <= '0;
      sig_q        <= 1'b0;
      hb_q         <= 1'b1;
      short_next_q <= 1'b1;
      hdr_q        <= '0;
      beeps_q      <= '0;
      idx_q        <= '0;
      total_q      <= '0;
      err_led_q    <= 1'b0;
      ok_led_q     <= 1'b1;
      rec_led_q    <= 1'b0;
    end else begin
      ticks_q      <= ticks_d;
      sig_q        <= sig_d;
      hb_q         <= hb_d;
      short_next_q <= short_next_d;
      hdr_q        <= hdr_d;
      beeps_q      <= beeps_d;
      idx_q        <= idx_d;
      total_q      <= total_d;
      err_led_q    <= err_led_d;
      ok_led_q     <= ok_led_d;
      rec_led_q    <= rec_led_d;
    end
  end

  // write at the fill position, forward it when the read hits the same entry
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (wr_en && wr_addr == idx_d) begin
      rd_q <= wr_data;
    end else begin
      rd_q <= mem_q[idx_d];
    end
  end

  assign flags_o.buzzer       = sig_d & cfg_i.buzzer_en;
  assign flags_o.error_led    = err_led_d;
  assign flags_o.all_ok_led   = ok_led_d;
  assign flags_o.recovery_led = rec_led_d;
  assign err_total_o          = total_d;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the error blink code sequencer: a class model of the
// heartbeat and error pattern player predicts one panel word per command word,
// and every panel word off the master stream is checked in order against it
// while both streams idle and stall at random between configuration phases
// ----------------------------------------------------------------------------

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ebcs_pkg::*;

  localparam int unsigned StoredW       = 5;      // errors_stored width for 16 codes
  localparam int unsigned PanelW        = 16;     // master tdata, padded to bytes
  localparam int unsigned MaxCodes      = 16;     // code list capacity
  localparam int unsigned CycleLimit    = 200000; // watchdog
  localparam int unsigned RandomPhases  = 8;
  localparam int unsigned WordsPerPhase = 70;
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7; // no register behind it

  // panel word as carried on the master stream, buzzer in bit 0
  typedef struct packed {
    logic [StoredW-1:0] errors_stored;
    logic               recovery_led;
    logic               all_ok_led;
    logic               error_led;
    logic               buzzer;
  } panel_t;

  // --------------------------------------------------------------------------
  // pattern model and in-order panel word checker
  // --------------------------------------------------------------------------
  class blink_scoreboard;
    time_t            short_t, long_t, code_on_t, code_gap_t;
    logic [HdrW-1:0]  first_hdr, later_hdr;
    logic             buzzer_en;

    time_t            ticks_left;
    logic             signal_on, heartbeat, short_next;
    logic [HdrW-1:0]  header_left;
    logic [CodeW-1:0] beeps_left;
    int unsigned      code_index, error_total;
    logic [CodeW-1:0] code_list [MaxCodes];
    logic             err_led, ok_led, rec_led;

    panel_t           panel_q[$];
    int unsigned      fails;

    function new();
      short_t     = 16'd100;
      long_t      = 16'd1000;
      code_on_t   = 16'd300;
      code_gap_t  = 16'd500;
      first_hdr   = 3'd3;
      later_hdr   = 3'd2;
      buzzer_en   = 1'b1;
      ticks_left  = '0;
      signal_on   = 1'b0;
      heartbeat   = 1'b1;
      short_next  = 1'b1;
      header_left = '0;
      beeps_left  = '0;
      code_index  = 0;
      error_total = 0;
      err_led     = 1'b0;
      ok_led      = 1'b1;
      rec_led     = 1'b0;
      fails       = 0;
    endfunction

    function void set_reg(input logic [CfgIdxW-1:0] idx, input logic [TimeW-1:0] val);
      case (idx)
        REG_SHORT_TIME:    short_t    = val;
        REG_LONG_TIME:     long_t     = val;
        REG_CODE_ON_TIME:  code_on_t  = val;
        REG_CODE_GAP_TIME: code_gap_t = val;
        REG_FIRST_HDR:     first_hdr  = val[HdrW-1:0];
        REG_LATER_HDR:     later_hdr  = val[HdrW-1:0];
        REG_BUZZER_EN:     buzzer_en  = val[0];
        default: ;
      endcase
    endfunction

    // a phase of d ticks, zero length runs as one tick
    function void load_phase(input time_t d);
      ticks_left = (d == '0) ? '0 : d - 1'b1;
    endfunction

    function logic [HdrW-1:0] header_total();
      logic [HdrW-1:0] n;
      n = (code_index == 0) ? first_hdr : later_hdr;
      return (n == '0) ? 3'd1 : n;
    endfunction

    // short beep, short pause, long beep, long pause
    function void heartbeat_step();
      if (!signal_on) begin
        signal_on = 1'b1;
        load_phase(short_next ? short_t : long_t);
      end else begin
        signal_on = 1'b0;
        if (short_next) begin
          short_next = 1'b0;
          load_phase(short_t);
        end else begin
          short_next = 1'b1;
          load_phase(long_t);
          // heartbeat ends only after a full cycle
          if (error_total != 0) heartbeat = 1'b0;
        end
      end
    endfunction

    // header beeps, then code beeps, then long pause, then the next code
    function void pattern_step();
      if (!signal_on) begin
        signal_on = 1'b1;
        err_led   = 1'b1;
        if (beeps_left == '0) begin
          if (header_left == '0) header_left = header_total();
          load_phase(short_t);
        end else begin
          load_phase(code_on_t);
        end
      end else begin
        signal_on = 1'b0;
        err_led   = 1'b0;
        if (header_left != '0) begin
          header_left = header_left - 1'b1;
          if (header_left != '0) begin
            load_phase(short_t);
          end else begin
            beeps_left = code_list[code_index];
            load_phase(code_gap_t);
          end
        end else begin
          if (beeps_left != '0) beeps_left = beeps_left - 1'b1;
          if (beeps_left != '0) begin
            load_phase(code_gap_t);
          end else begin
            load_phase(long_t);
            code_index++;
            if (code_index >= error_total) code_index = 0;
          end
        end
      end
    endfunction

    // advance the model by one accepted command word and queue its panel word
    function void note_word(input logic [CmdW-1:0] cmd, input logic [CodeW-1:0] code,
                            input logic lvl);
      logic [CodeW-1:0] fixed;
      panel_t           p;
      case (cmd)
        CMD_TICK: begin
          if (ticks_left != '0) ticks_left = ticks_left - 1'b1;
          else if (heartbeat) heartbeat_step();
          else pattern_step();
        end
        CMD_REPORT: begin
          ok_led = 1'b0;
          // zero and out of range codes play as the last code
          fixed = (code == '0 || code >= CODE_COUNT) ? CodeLast : code;
          if (error_total < MaxCodes) begin
            code_list[error_total] = fixed;
            error_total++;
          end
        end
        CMD_RECOVER: rec_led = 1'b1;
        default: begin
          // radio led only counts while the list is empty
          if (error_total == 0) ok_led = lvl;
        end
      endcase
      p.buzzer        = signal_on & buzzer_en;
      p.error_led     = err_led;
      p.all_ok_led    = ok_led;
      p.recovery_led  = rec_led;
      p.errors_stored = StoredW'(error_total);
      panel_q.push_back(p);
    endfunction

    function void report_field(input string name, input int unsigned want,
                               input int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        fails++;
      end
    endfunction

    function void check_word(input logic [PanelW-1:0] data);
      panel_t got, want;
      got = panel_t'(data[$bits(panel_t)-1:0]);
      if (panel_q.size() == 0) begin
        $display("%0t: unexpected panel word, expected none actual %h", $time, data);
        fails++;
        return;
      end
      want = panel_q.pop_front();
      report_field("buzzer", want.buzzer, got.buzzer);
      report_field("error_led", want.error_led, got.error_led);
      report_field("all_ok_led", want.all_ok_led, got.all_ok_led);
      report_field("recovery_led", want.recovery_led, got.recovery_led);
      report_field("errors_stored", want.errors_stored, got.errors_stored);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block inputs, all known from time zero
  // --------------------------------------------------------------------------
  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [CmdW-1:0]     s_axis_tuser  = '0;
  logic                m_axis_tready = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [TimeW-1:0]    cfg_data_i    = '0;

  wire logic              s_axis_tready;
  wire logic              m_axis_tvalid;
  wire logic [PanelW-1:0] m_axis_tdata;

  blink_scoreboard sb;
  logic            no_idle = 1'b0;  // both sides run back to back when set
  int unsigned     cycle_count = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  error_blink_code_sequencer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // error_code[3:0], led_level[4]
    .s_axis_tuser  (s_axis_tuser),   // cmd[1:0]
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // buzzer[0], error_led[1], all_ok_led[2],
                                     // recovery_led[3], errors_stored[8:4]
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // watchdog, a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL error_blink_code_sequencer");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------

  // offer one command word after a random gap, return at the edge it is taken
  task automatic send_word(input logic [CmdW-1:0] cmd, input logic [CodeW-1:0] code,
                           input logic lvl);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {3'b000, lvl, code};
    // values sampled here are the ones of the edge itself
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(cmd, code, lvl);
  endtask

  // mostly ticks, with reports, radio led levels and recovery mixed in;
  // unused fields carry random noise
  task automatic random_word(input int unsigned report_pct);
    int unsigned     roll;
    logic [CmdW-1:0] cmd;
    roll = $urandom_range(0, 99);
    if (roll < report_pct)          cmd = CMD_REPORT;
    else if (roll < report_pct + 6) cmd = CMD_LED;
    else if (roll < report_pct + 9) cmd = CMD_RECOVER;
    else                            cmd = CMD_TICK;
    send_word(cmd, CodeW'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
  endtask

  // stop offering and wait until every panel word is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.panel_q.size() != 0) @(posedge clk_i);
  endtask

  // write enable stays high across back to back writes
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TimeW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic configure(input time_t short_v, input time_t long_v, input time_t on_v,
                           input time_t gap_v, input logic [HdrW-1:0] first_v,
                           input logic [HdrW-1:0] later_v, input logic bz_v);
    write_reg(REG_SHORT_TIME, short_v);
    write_reg(REG_LONG_TIME, long_v);
    write_reg(REG_CODE_ON_TIME, on_v);
    write_reg(REG_CODE_GAP_TIME, gap_v);
    write_reg(REG_FIRST_HDR, TimeW'(first_v));
    write_reg(REG_LATER_HDR, TimeW'(later_v));
    write_reg(REG_BUZZER_EN, TimeW'(bz_v));
    // unknown index must leave everything alone
    write_reg(REG_UNUSED, TimeW'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // short random phases keep the patterns moving within a few dozen ticks
  task automatic configure_random();
    configure(TimeW'($urandom_range(0, 4)), TimeW'($urandom_range(0, 4)),
              TimeW'($urandom_range(0, 4)), TimeW'($urandom_range(0, 4)),
              HdrW'($urandom_range(0, 7)), HdrW'($urandom_range(0, 7)),
              1'($urandom_range(0, 3) != 0));
  endtask

  // result side, random stall before each panel word
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_word(m_axis_tdata);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned report_pct;
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: first heartbeat beep, radio led levels, recovery latch
    send_word(CMD_TICK, 4'hF, 1'b1);
    send_word(CMD_LED, 4'h0, 1'b0);
    send_word(CMD_LED, 4'hF, 1'b1);
    send_word(CMD_RECOVER, 4'h0, 1'b0);
    send_word(CMD_TICK, 4'h0, 1'b0);
    send_word(CMD_LED, 4'h5, 1'b0);
    send_word(CMD_RECOVER, 4'hA, 1'b1);
    drain();

    // zero lengths run as one tick, zero header counts as one, buzzer muted
    configure('0, '0, '0, '0, '0, '0, 1'b0);
    repeat (8) send_word(CMD_TICK, CodeW'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    drain();

    // heartbeat only, no reports yet
    configure_random();
    repeat (60) random_word(0);

    // reports: code zero, smallest, last, just out of range, largest field value
    send_word(CMD_REPORT, 4'd0, 1'b0);
    send_word(CMD_REPORT, 4'd1, 1'b1);
    send_word(CMD_REPORT, 4'd9, 1'b0);
    send_word(CMD_REPORT, 4'd10, 1'b1);
    send_word(CMD_REPORT, 4'd15, 1'b1);

    // random phases; reports come faster in the middle so the list fills up,
    // the maximum lengths go last since they freeze the pattern
    for (int unsigned phase = 0; phase < RandomPhases; phase++) begin
      drain();
      if (phase == 0)
        configure(16'd1, 16'd1, 16'd1, 16'd1, 3'd7, 3'd7, 1'b1);
      else if (phase == RandomPhases - 1)
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7, 3'd7, 1'b1);
      else
        configure_random();
      no_idle    = (phase % 3 == 2);
      report_pct = (phase < 4) ? 1 : ((phase < 6) ? 6 : 3);
      repeat (WordsPerPhase) random_word(report_pct);
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (sb.fails == 0) begin
      $display("PASS error_blink_code_sequencer");
    end else begin
      $display("FAIL error_blink_code_sequencer");
    end
    $finish;
  end

endmodule
